>>> sv/vup_pkg.sv
// Shared types, constants and helper functions of the VLAN/UDP PRBS frame generator.
package vup_pkg;

   // Frame geometry
   localparam int PAYLOAD_BYTES = 1467;
   localparam int HEADER_BYTES  = 46;
   localparam int FRAME_BYTES   = HEADER_BYTES + PAYLOAD_BYTES;
   localparam int PRBS_START    = HEADER_BYTES + 8;
   localparam int DTN_POS       = FRAME_BYTES - 1;
   localparam int POS_W         = $clog2(FRAME_BYTES);
   localparam int INDEX_W       = 11;

   // Length fields of the IPv4 and UDP headers
   localparam logic [15:0] IP_TOTAL_LEN = 16'(20 + 8 + PAYLOAD_BYTES);
   localparam logic [15:0] UDP_LEN      = 16'(8 + PAYLOAD_BYTES);

   // Fixed header bytes
   localparam logic [7:0]  MAC_MCAST_BYTE = 8'h03;
   localparam logic [7:0]  VLAN_TPID_HI   = 8'h81;
   localparam logic [7:0]  IPV4_TYPE_HI   = 8'h08;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TTL         = 8'h01;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
   localparam logic [7:0]  IP_MCAST_BYTE  = 8'hE0;
   // The constant part of the checksum sum overflows 16 bits, so it keeps its carries.
   localparam logic [17:0] CSUM_CONST     = 18'h04500 + 18'(IP_TOTAL_LEN) + 18'h00111
                                          + 18'h0E0E0;

   // PRBS-31
   localparam int          LFSR_W     = 31;
   localparam logic [30:0] SEED_RESET = 31'h7F3A2B01;

   // Register reset values
   localparam logic [15:0] LINK_ID_RESET     = 16'd161;
   localparam logic [11:0] VLAN_NUMBER_RESET = 12'd97;
   localparam logic [2:0]  VLAN_PRIO_RESET   = 3'd0;
   localparam logic [47:0] SOURCE_MAC_RESET  = 48'h020000000040;
   localparam logic [31:0] SOURCE_IP_RESET   = 32'h0A000000;
   localparam logic [15:0] UDP_PORT_RESET    = 16'd100;
   localparam logic [31:0] BASE_SEED_RESET   = 32'h7F3A2B01;

   // Register map
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef enum logic [2:0] {
      REG_LINK_ID     = 3'd0,
      REG_VLAN_NUMBER = 3'd1,
      REG_VLAN_PRIO   = 3'd2,
      REG_SOURCE_MAC  = 3'd3,
      REG_SOURCE_IP   = 3'd4,
      REG_UDP_SRC     = 3'd5,
      REG_UDP_DST     = 3'd6,
      REG_BASE_SEED   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] link_id;
      logic [11:0] vlan_number;
      logic [2:0]  vlan_prio;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [15:0] udp_source_port;
      logic [15:0] udp_dest_port;
      logic [31:0] prbs_base_seed;
   } cfg_type;

   // Region of the frame that a byte falls into
   typedef enum logic [1:0] {
      KIND_HDR,
      KIND_SEQ,
      KIND_PRBS,
      KIND_DTN
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [POS_W-1:0] pos;
      logic             start;
      logic             last;
      logic [7:0]       seq_byte;
      logic [30:0]      seed;
      logic [7:0]       dtn;
   } entry_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // PRBS seed of a frame: low 31 bits of base plus sequence, never zero.
   function automatic logic [30:0] seed_for(input logic [31:0] base, input logic [31:0] seq_lo);
      logic [31:0] sum;
      sum = base + seq_lo;
      return (sum[30:0] == 31'd0) ? 31'd1 : sum[30:0];
   endfunction

   // Frame counter byte: zero for sequence zero, else ((seq-1) mod 255)+1.
   // Since 256 is 1 mod 255, the byte sum folded with end-around carry
   // lands on 1..255 for any nonzero sequence.
   function automatic logic [7:0] dtn_for(input logic [63:0] seq);
      logic [10:0] sum;
      logic [8:0]  fold1;
      logic [8:0]  fold2;
      sum = 11'd0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + 11'(seq[8*i +: 8]);
      end
      fold1 = 9'(sum[7:0]) + 9'(sum[10:8]);
      fold2 = 9'(fold1[7:0]) + 9'(fold1[8]);
      return fold2[7:0];
   endfunction

endpackage

>>> sv/vup_if.sv
// Handshake channels for frame byte requests and generated bytes.
interface vup_req_if;
   logic        valid;
   logic        ready;
   logic        new_packet;
   logic [63:0] seq_value;

   modport source (output valid, output new_packet, output seq_value, input ready);
   modport sink   (input valid, input new_packet, input seq_value, output ready);
endinterface

interface vup_rsp_if import vup_pkg::*;;
   logic               valid;
   logic               ready;
   logic [7:0]         data_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               last_byte;

   modport source (output valid, output data_byte, output byte_index, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_index, input last_byte,
                   output ready);
endinterface

>>> sv/vup_csr.sv
// Configuration registers with APB-style access and the IPv4 header checksum.
module vup_csr import vup_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic [15:0]           ip_csum
);

   cfg_type       cfg_ff, cfg_in;
   logic [15:0]   csum_ff, csum_in;
   reg_index_type reg_sel;
   logic          wr_en;
   logic [18:0]   csum_sum;
   logic [16:0]   csum_fold1;
   logic [16:0]   csum_fold2;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[5:3]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LINK_ID:     cfg_in.link_id         = pwdata[15:0];
            REG_VLAN_NUMBER: cfg_in.vlan_number     = pwdata[11:0];
            REG_VLAN_PRIO:   cfg_in.vlan_prio       = pwdata[2:0];
            REG_SOURCE_MAC:  cfg_in.source_mac      = pwdata[47:0];
            REG_SOURCE_IP:   cfg_in.source_ip       = pwdata[31:0];
            REG_UDP_SRC:     cfg_in.udp_source_port = pwdata[15:0];
            REG_UDP_DST:     cfg_in.udp_dest_port   = pwdata[15:0];
            REG_BASE_SEED:   cfg_in.prbs_base_seed  = pwdata[31:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LINK_ID:     prdata = CSR_DATA_W'(cfg_ff.link_id);
         REG_VLAN_NUMBER: prdata = CSR_DATA_W'(cfg_ff.vlan_number);
         REG_VLAN_PRIO:   prdata = CSR_DATA_W'(cfg_ff.vlan_prio);
         REG_SOURCE_MAC:  prdata = CSR_DATA_W'(cfg_ff.source_mac);
         REG_SOURCE_IP:   prdata = CSR_DATA_W'(cfg_ff.source_ip);
         REG_UDP_SRC:     prdata = CSR_DATA_W'(cfg_ff.udp_source_port);
         REG_UDP_DST:     prdata = CSR_DATA_W'(cfg_ff.udp_dest_port);
         REG_BASE_SEED:   prdata = CSR_DATA_W'(cfg_ff.prbs_base_seed);
         default:         prdata = '0;
      endcase
   end

   // Ones-complement header checksum; two end-around folds bring the sum into 16 bits.
   always_comb begin
      csum_sum   = 19'(CSUM_CONST) + 19'(cfg_ff.source_ip[31:16])
                 + 19'(cfg_ff.source_ip[15:0]) + 19'(cfg_ff.link_id);
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[18:16]);
      csum_fold2 = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);
      csum_in    = ~csum_fold2[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_id         <= LINK_ID_RESET;
         cfg_ff.vlan_number     <= VLAN_NUMBER_RESET;
         cfg_ff.vlan_prio       <= VLAN_PRIO_RESET;
         cfg_ff.source_mac      <= SOURCE_MAC_RESET;
         cfg_ff.source_ip       <= SOURCE_IP_RESET;
         cfg_ff.udp_source_port <= UDP_PORT_RESET;
         cfg_ff.udp_dest_port   <= UDP_PORT_RESET;
         cfg_ff.prbs_base_seed  <= BASE_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
      csum_ff <= csum_in;
   end

   assign cfg     = cfg_ff;
   assign ip_csum = csum_ff;

endmodule

>>> sv/vup_front.sv
// Request side: tracks frame position and sequence, classifies each byte for the back end.
module vup_front import vup_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   vup_req_if.sink  req_ch,
   input  cfg_type  cfg,
   input  logic     queue_full,
   output logic     push,
   output entry_type push_data
);

   logic [63:0]      frame_seq_ff, frame_seq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0]      seq_cur;
   logic [POS_W-1:0] pos_cur;
   logic             is_last;
   logic [2:0]       seq_off;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && req_ch.ready;

   assign seq_cur = req_ch.new_packet ? req_ch.seq_value : frame_seq_ff;
   assign pos_cur = req_ch.new_packet ? '0 : pos_ff;
   assign is_last = (pos_cur == POS_W'(DTN_POS));
   assign seq_off = pos_cur[2:0] - 3'(HEADER_BYTES);

   always_comb begin
      push_data.pos      = pos_cur;
      push_data.start    = (pos_cur == '0);
      push_data.last     = is_last;
      push_data.seq_byte = seq_cur[8*seq_off +: 8];
      push_data.seed     = seed_for(cfg.prbs_base_seed, seq_cur[31:0]);
      push_data.dtn      = dtn_for(seq_cur);
      if (pos_cur < POS_W'(HEADER_BYTES)) begin
         push_data.kind = KIND_HDR;
      end else if (pos_cur < POS_W'(PRBS_START)) begin
         push_data.kind = KIND_SEQ;
      end else if (pos_cur < POS_W'(DTN_POS)) begin
         push_data.kind = KIND_PRBS;
      end else begin
         push_data.kind = KIND_DTN;
      end
   end

   always_comb begin
      frame_seq_in = frame_seq_ff;
      pos_in       = pos_ff;
      if (push) begin
         if (is_last) begin
            frame_seq_in = seq_cur + 64'd1;
            pos_in       = '0;
         end else begin
            frame_seq_in = seq_cur;
            pos_in       = pos_cur + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_seq_ff <= '0;
         pos_ff       <= '0;
      end else begin
         frame_seq_ff <= frame_seq_in;
         pos_ff       <= pos_in;
      end
   end

   // A frame end always restarts at byte zero with the next sequence number.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      push && is_last |=> pos_ff == '0 && frame_seq_ff == $past(seq_cur) + 64'd1)
      else $error("frame did not wrap to the next sequence");

endmodule

>>> sv/vup_queue.sv
// Short queue of classified items between the front and the back end.
module vup_queue import vup_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH) && !(pop && empty))
      else $error("queue over- or underflow");

endmodule

>>> sv/vup_back.sv
// Byte side: builds header bytes, runs the PRBS-31 generator and registers the output.
module vup_back import vup_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic [15:0] ip_csum,
   input  logic      queue_empty,
   input  entry_type pop_data,
   output logic      pop,
   vup_rsp_if.source rsp_ch
);

   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [7:0]         dtn_ff, dtn_in;
   logic               valid_ff, valid_in;
   logic [7:0]         data_ff, data_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               last_ff, last_in;

   logic [LFSR_W-1:0]  lfsr_base;
   logic [LFSR_W-1:0]  lfsr_step;
   logic [7:0]         prbs_byte;
   logic [7:0]         dtn_cur;
   logic [7:0]         hdr_byte;
   logic [15:0]        tci;
   logic               out_free;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign pop      = !queue_empty && out_free;

   // Eight generator steps per byte, most significant bit first.
   always_comb begin
      lfsr_base = pop_data.start ? pop_data.seed : lfsr_ff;
      lfsr_step = lfsr_base;
      prbs_byte = 8'd0;
      for (int k = 0; k < 8; k++) begin
         lfsr_step = {lfsr_step[LFSR_W-2:0], lfsr_step[30] ^ lfsr_step[27]};
         prbs_byte = {prbs_byte[6:0], lfsr_step[0]};
      end
   end

   assign dtn_cur = pop_data.start ? pop_data.dtn : dtn_ff;
   assign tci     = {cfg.vlan_prio, 1'b0, cfg.vlan_number};

   always_comb begin
      case (pop_data.pos[5:0])
         6'd0:    hdr_byte = MAC_MCAST_BYTE;
         6'd4:    hdr_byte = cfg.link_id[15:8];
         6'd5:    hdr_byte = cfg.link_id[7:0];
         6'd6:    hdr_byte = cfg.source_mac[47:40];
         6'd7:    hdr_byte = cfg.source_mac[39:32];
         6'd8:    hdr_byte = cfg.source_mac[31:24];
         6'd9:    hdr_byte = cfg.source_mac[23:16];
         6'd10:   hdr_byte = cfg.source_mac[15:8];
         6'd11:   hdr_byte = cfg.source_mac[7:0];
         6'd12:   hdr_byte = VLAN_TPID_HI;
         6'd14:   hdr_byte = tci[15:8];
         6'd15:   hdr_byte = tci[7:0];
         6'd16:   hdr_byte = IPV4_TYPE_HI;
         6'd18:   hdr_byte = IP_VER_IHL;
         6'd20:   hdr_byte = IP_TOTAL_LEN[15:8];
         6'd21:   hdr_byte = IP_TOTAL_LEN[7:0];
         6'd26:   hdr_byte = IP_TTL;
         6'd27:   hdr_byte = IP_PROTO_UDP;
         6'd28:   hdr_byte = ip_csum[15:8];
         6'd29:   hdr_byte = ip_csum[7:0];
         6'd30:   hdr_byte = cfg.source_ip[31:24];
         6'd31:   hdr_byte = cfg.source_ip[23:16];
         6'd32:   hdr_byte = cfg.source_ip[15:8];
         6'd33:   hdr_byte = cfg.source_ip[7:0];
         6'd34:   hdr_byte = IP_MCAST_BYTE;
         6'd35:   hdr_byte = IP_MCAST_BYTE;
         6'd36:   hdr_byte = cfg.link_id[15:8];
         6'd37:   hdr_byte = cfg.link_id[7:0];
         6'd38:   hdr_byte = cfg.udp_source_port[15:8];
         6'd39:   hdr_byte = cfg.udp_source_port[7:0];
         6'd40:   hdr_byte = cfg.udp_dest_port[15:8];
         6'd41:   hdr_byte = cfg.udp_dest_port[7:0];
         6'd42:   hdr_byte = UDP_LEN[15:8];
         6'd43:   hdr_byte = UDP_LEN[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      lfsr_in  = lfsr_ff;
      dtn_in   = dtn_ff;
      data_in  = data_ff;
      index_in = index_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      if (pop) begin
         valid_in = 1'b1;
         index_in = INDEX_W'(pop_data.pos);
         last_in  = pop_data.last;
         dtn_in   = dtn_cur;
         lfsr_in  = (pop_data.kind == KIND_PRBS) ? lfsr_step : lfsr_base;
         unique case (pop_data.kind)
            KIND_HDR:  data_in = hdr_byte;
            KIND_SEQ:  data_in = pop_data.seq_byte;
            KIND_PRBS: data_in = prbs_byte;
            KIND_DTN:  data_in = dtn_cur;
            default:   data_in = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lfsr_ff  <= SEED_RESET;
         dtn_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         lfsr_ff  <= lfsr_in;
         dtn_ff   <= dtn_in;
      end
      data_ff  <= data_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.data_byte  = data_ff;
   assign rsp_ch.byte_index = index_ff;
   assign rsp_ch.last_byte  = last_ff;

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> index_ff == INDEX_W'(DTN_POS))
      else $error("last byte flagged away from the frame end");

   a_start_hdr: assert property (@(posedge clock) disable iff (reset)
      pop && pop_data.start |-> pop_data.kind == KIND_HDR)
      else $error("frame start outside the header");

   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("PRBS generator reached the all-zero state");

endmodule

>>> sv/vlan_udp_prbs_packet_generator_unit.sv
// Top level of the VLAN/UDP PRBS-31 test frame generator.
//
//   Channel   Direction  Handshake          Payload
//   req_ch    in         valid/ready        new_packet, seq_value
//   rsp_ch    out        valid/ready        data_byte, byte_index, last_byte
//   apb       in         psel/penable       paddr, pwdata, pwrite -> prdata
//
// One item per clock sustained while rsp_ch is not stalled; a byte is offered on rsp_ch after
// its request is accepted, held first in the queue and then in the output register.
// The PRBS generator advances all eight steps combinationally, so bytes never wait on it.
// Synchronous reset clears position, sequence and the queue; frame 0 starts at byte 0.
// A stalled output lets up to four more requests collect in the queue before req_ch.ready falls.
module vlan_udp_prbs_packet_generator_unit import vup_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vup_req_if.sink               req_ch,
   vup_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type     cfg;
   logic [15:0] ip_csum;
   logic        push;
   entry_type   push_data;
   logic        queue_full;
   logic        pop;
   entry_type   pop_data;
   logic        queue_empty;

   vup_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .ip_csum (ip_csum)
   );

   vup_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   vup_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   vup_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .ip_csum     (ip_csum),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

>>> tb/vup_frame_scoreboard.sv
// Scoreboard for the VLAN/UDP PRBS frame generator: mirrors the frame layout and checks every byte.
`timescale 1ns / 1ps

module vup_frame_scoreboard import vup_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vup_req_if                    req_ch,
   vup_rsp_if                    rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    pending,
   output int                    bytes_checked,
   output int                    frames_done
);

   typedef struct packed {
      logic [7:0]         data;
      logic [INDEX_W-1:0] index;
      logic               last;
   } byte_result_type;

   byte_result_type frame_bytes_due[$];

   cfg_type     cfg;
   logic [63:0] cur_seq;
   int unsigned cur_pos;
   logic [30:0] prbs_reg;
   logic [7:0]  cur_dtn;
   int          fail_count;
   int          checked_count;
   int          frame_count;

   function automatic logic [30:0] prbs_seed(input logic [63:0] seq);
      logic [31:0] sum;
      sum = cfg.prbs_base_seed + seq[31:0];
      return (sum[30:0] == 31'd0) ? 31'd1 : sum[30:0];
   endfunction

   function automatic logic [7:0] frame_counter(input logic [63:0] seq);
      logic [63:0] m;
      if (seq == 64'd0) return 8'd0;
      m = (seq - 64'd1) % 64'd255;
      return 8'(m + 64'd1);
   endfunction

   function automatic logic [15:0] header_checksum();
      logic [31:0] acc;
      acc = 32'h4500 + {16'h0, IP_TOTAL_LEN} + 32'h0111 + 32'hE0E0
            + {16'h0, cfg.source_ip[31:16]} + {16'h0, cfg.source_ip[15:0]}
            + {16'h0, cfg.link_id};
      while (acc[31:16] != 16'd0) acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   function automatic logic [7:0] header_byte(input int unsigned p);
      logic [15:0] tci;
      logic [15:0] csum;
      tci  = {cfg.vlan_prio, 1'b0, cfg.vlan_number};
      csum = header_checksum();
      if (p < 4) return (p == 0) ? MAC_MCAST_BYTE : 8'h00;
      if (p == 4) return cfg.link_id[15:8];
      if (p == 5) return cfg.link_id[7:0];
      if (p < 12) return cfg.source_mac[8*(11-p) +: 8];
      if (p >= 30 && p < 34) return cfg.source_ip[8*(33-p) +: 8];
      case (p)
         12: return VLAN_TPID_HI;
         14: return tci[15:8];
         15: return tci[7:0];
         16: return IPV4_TYPE_HI;
         18: return IP_VER_IHL;
         20: return IP_TOTAL_LEN[15:8];
         21: return IP_TOTAL_LEN[7:0];
         26: return IP_TTL;
         27: return IP_PROTO_UDP;
         28: return csum[15:8];
         29: return csum[7:0];
         34, 35: return IP_MCAST_BYTE;
         36: return cfg.link_id[15:8];
         37: return cfg.link_id[7:0];
         38: return cfg.udp_source_port[15:8];
         39: return cfg.udp_source_port[7:0];
         40: return cfg.udp_dest_port[15:8];
         41: return cfg.udp_dest_port[7:0];
         42: return UDP_LEN[15:8];
         43: return UDP_LEN[7:0];
         default: return 8'h00;
      endcase
   endfunction

   // Eight LFSR steps per byte, the newest bit lands in the LSB of the byte.
   function automatic logic [7:0] next_prbs_byte();
      logic [7:0] b;
      logic       fb;
      b = 8'h00;
      for (int k = 0; k < 8; k++) begin
         fb       = prbs_reg[30] ^ prbs_reg[27];
         prbs_reg = {prbs_reg[29:0], fb};
         b        = {b[6:0], fb};
      end
      return b;
   endfunction

   function automatic byte_result_type next_frame_byte(input logic        restart,
                                                       input logic [63:0] seq);
      byte_result_type b;
      int unsigned     p;
      if (restart) begin
         cur_seq = seq;
         cur_pos = 0;
      end
      if (cur_pos >= FRAME_BYTES) cur_pos = 0;
      p = cur_pos;
      // The PRBS seed and the trailing counter are latched at every frame start.
      if (p == 0) begin
         prbs_reg = prbs_seed(cur_seq);
         cur_dtn  = frame_counter(cur_seq);
      end
      if (p < HEADER_BYTES) b.data = header_byte(p);
      else if (p < PRBS_START) b.data = cur_seq[8*(p-HEADER_BYTES) +: 8];
      else if (p < DTN_POS) b.data = next_prbs_byte();
      else b.data = cur_dtn;
      b.index = INDEX_W'(p);
      b.last  = (p == DTN_POS);
      if (b.last) begin
         cur_pos = 0;
         cur_seq = cur_seq + 64'd1;
      end else begin
         cur_pos = p + 1;
      end
      return b;
   endfunction

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      byte_result_type want;
      if (reset) begin
         cfg = '{LINK_ID_RESET, VLAN_NUMBER_RESET, VLAN_PRIO_RESET, SOURCE_MAC_RESET,
                 SOURCE_IP_RESET, UDP_PORT_RESET, UDP_PORT_RESET, BASE_SEED_RESET};
         cur_seq  = 64'd0;
         cur_pos  = 0;
         cur_dtn  = 8'd0;
         prbs_reg = prbs_seed(64'd0);
         frame_bytes_due.delete();
         fail_count    = 0;
         checked_count = 0;
         frame_count   = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[5:3]))
               REG_LINK_ID:     cfg.link_id         = pwdata[15:0];
               REG_VLAN_NUMBER: cfg.vlan_number     = pwdata[11:0];
               REG_VLAN_PRIO:   cfg.vlan_prio       = pwdata[2:0];
               REG_SOURCE_MAC:  cfg.source_mac      = pwdata[47:0];
               REG_SOURCE_IP:   cfg.source_ip       = pwdata[31:0];
               REG_UDP_SRC:     cfg.udp_source_port = pwdata[15:0];
               REG_UDP_DST:     cfg.udp_dest_port   = pwdata[15:0];
               REG_BASE_SEED:   cfg.prbs_base_seed  = pwdata[31:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            frame_bytes_due.push_back(next_frame_byte(req_ch.new_packet, req_ch.seq_value));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: unexpected item, got data %0h index %0d last %0b", $time,
                        rsp_ch.data_byte, rsp_ch.byte_index, rsp_ch.last_byte);
               fail_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               report_field("data_byte", 64'(want.data), 64'(rsp_ch.data_byte));
               report_field("byte_index", 64'(want.index), 64'(rsp_ch.byte_index));
               report_field("last_byte", 64'(want.last), 64'(rsp_ch.last_byte));
               checked_count++;
               if (want.last) frame_count++;
            end
         end
      end
      mismatches    <= fail_count;
      pending       <= frame_bytes_due.size();
      bytes_checked <= checked_count;
      frames_done   <= frame_count;
   end

endmodule

>>> tb/vlan_udp_prbs_packet_generator_unit_test.sv
// Top of the frame generator testbench: clock, reset, stimulus, stalls and the final verdict.
`timescale 1ns / 1ps

module vlan_udp_prbs_packet_generator_unit_test;
   import vup_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    pending;
   int                    bytes_checked;
   int                    frames_done;
   int                    quiet_cycles = 0;
   int                    burst_left;
   cfg_type               setting;

   vup_req_if req_ch ();
   vup_rsp_if rsp_ch ();

   vlan_udp_prbs_packet_generator_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   vup_frame_scoreboard u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .mismatches    (mismatches),
      .pending       (pending),
      .bytes_checked (bytes_checked),
      .frames_done   (frames_done)
   );

   always #5 clock = ~clock;

   // Any accepted item or register access counts as progress.
   always @(posedge clock) begin
      if (reset || psel || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: changing stall patterns, plus two long hold-offs that back up the block.
   initial begin
      int hold_left;
      int holds_done;
      int mode;
      int mode_left;
      int tick;
      hold_left    = 0;
      holds_done   = 0;
      mode         = 0;
      mode_left    = 0;
      tick         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left == 0 && ((holds_done == 0 && bytes_checked >= 400) ||
                                (holds_done == 1 && bytes_checked >= 1000))) begin
            hold_left = 300;
            holds_done++;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (tick % 4 != 3);
               default: rsp_ch.ready <= (tick % 7 < 2);
            endcase
         end
      end
   end

   // Offers one item; between bursts the valid line may drop for a random gap.
   task automatic send_item(input logic restart, input logic [63:0] seq);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      end
      req_ch.valid      <= 1'b1;
      req_ch.new_packet <= restart;
      req_ch.seq_value  <= seq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic run_segment(input logic restart, input logic [63:0] seq, input int length);
      send_item(restart, seq);
      for (int i = 1; i < length; i++) send_item(1'b0, {$urandom, $urandom});
   endtask

   // Stops offering and waits until every generated byte has been checked.
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input int width,
                            input logic [63:0] value, input logic junk);
      logic [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= (value & mask) | (junk ? ({$urandom, $urandom} & ~mask) : 64'd0);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type s, input logic junk);
      csr_write(REG_LINK_ID, 16, 64'(s.link_id), junk);
      csr_write(REG_VLAN_NUMBER, 12, 64'(s.vlan_number), junk);
      csr_write(REG_VLAN_PRIO, 3, 64'(s.vlan_prio), junk);
      csr_write(REG_SOURCE_MAC, 48, 64'(s.source_mac), junk);
      csr_write(REG_SOURCE_IP, 32, 64'(s.source_ip), junk);
      csr_write(REG_UDP_SRC, 16, 64'(s.udp_source_port), junk);
      csr_write(REG_UDP_DST, 16, 64'(s.udp_dest_port), junk);
      csr_write(REG_BASE_SEED, 32, 64'(s.prbs_base_seed), junk);
   endtask

   // Sequence numbers that hit the extremes, or make the PRBS seed come out zero.
   function automatic logic [63:0] pick_seq();
      case ($urandom_range(0, 6))
         0: return 64'd0;
         1: return '1;
         2: return {$urandom, 32'd0 - setting.prbs_base_seed};
         3: return {$urandom, 32'h8000_0000 - setting.prbs_base_seed};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int phase_items;
      int len;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_ch.valid      = 1'b0;
      req_ch.new_packet = 1'b0;
      req_ch.seq_value  = '0;
      burst_left        = 0;
      setting = '{LINK_ID_RESET, VLAN_NUMBER_RESET, VLAN_PRIO_RESET, SOURCE_MAC_RESET,
                  SOURCE_IP_RESET, UDP_PORT_RESET, UDP_PORT_RESET, BASE_SEED_RESET};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: first frame after reset, extreme and alternating sequence numbers,
      // a seed that folds to zero, then a run over the MAC addresses into the VLAN tag.
      run_segment(1'b0, 64'd0, 3);
      run_segment(1'b1, '1, 3);
      send_item(1'b1, {32'd0, 32'd0 - BASE_SEED_RESET});
      send_item(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(1'b1, 64'h5555_5555_5555_5555);
      run_segment(1'b1, 64'h8000_0000_0000_0000, 13);

      for (int phase = 0; phase < 4; phase++) begin
         phase_items = 0;
         if (phase > 0) begin
            drain();
            repeat (4) @(posedge clock);
            case (phase)
               1: setting = '0;
               2: setting = '1;
               default: begin
                  setting.link_id         = 16'($urandom);
                  setting.vlan_number     = 12'($urandom);
                  setting.vlan_prio       = 3'($urandom);
                  setting.source_mac      = 48'({$urandom, $urandom});
                  setting.source_ip       = $urandom;
                  setting.udp_source_port = 16'($urandom);
                  setting.udp_dest_port   = 16'($urandom);
                  setting.prbs_base_seed  = $urandom;
               end
            endcase
            write_settings(setting, phase == 3);
         end
         // One whole frame plus the start of the next, so the frame end and the
         // automatic sequence step are seen; the all-ones sequence wraps to zero.
         if (phase == 2) begin
            run_segment(1'b1, '1, FRAME_BYTES + 56);
            phase_items = FRAME_BYTES + 56;
         end
         while (phase_items < 16) begin
            len = $urandom_range(4, 12);
            run_segment($urandom_range(0, 4) != 0, pick_seq(), len);
            phase_items += len;
            if ($urandom_range(0, 5) == 0) drain();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Checked %0d generated bytes and %0d frame ends over four register settings,",
               bytes_checked, frames_done);
      $display("with random sender gaps, receiver stalls and two long output hold-offs.");
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
sv/vup_pkg.sv
sv/vup_if.sv
sv/vup_csr.sv
sv/vup_front.sv
sv/vup_queue.sv
sv/vup_back.sv
sv/vlan_udp_prbs_packet_generator_unit.sv
tb/vup_frame_scoreboard.sv
tb/vlan_udp_prbs_packet_generator_unit_test.sv
